### sv/mhps_pkg.sv
// ----------------------------------------------------------------------------
// mhps_pkg
// Shared constants, types and helper functions for the pair-search engine.
// ----------------------------------------------------------------------------
package mhps_pkg;

  // slab geometry
  localparam int SLAB_BITS = 16;

  // field widths
  localparam int IDX_W   = 32;
  localparam int WORD_W  = 64;
  localparam int CFG_IDX_W = 2;

  // operation codes
  localparam logic OP_FILL   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFFICULTY = 2'd2;

  // SipHash init words and finalization constants
  localparam logic [WORD_W-1:0] SIP_C0  = 64'h736f6d6570736575;
  localparam logic [WORD_W-1:0] SIP_C1  = 64'h646f72616e646f6d;
  localparam logic [WORD_W-1:0] SIP_C2  = 64'h6c7967656e657261;
  localparam logic [WORD_W-1:0] SIP_C3  = 64'h7465646279746573;
  localparam logic [WORD_W-1:0] SIP_B   = 64'h0800000000000000;
  localparam logic [WORD_W-1:0] SIP_FF  = 64'h00000000000000ff;
  localparam logic [WORD_W-1:0] TOP_BIT = 64'h8000000000000000;

  // round schedule: 2 compression rounds, then 2 + 4 rounds around finalization
  localparam int ROUND_W = 3;
  localparam logic [ROUND_W-1:0] RND_MSG_FOLD = 3'd2;
  localparam logic [ROUND_W-1:0] RND_FINAL    = 3'd4;
  localparam logic [ROUND_W-1:0] RND_LAST     = 3'd7;

  typedef logic [3:0][WORD_W-1:0] sip_v_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int s);
    rotl = (x << s) | (x >> (WORD_W - s));
  endfunction

  function automatic sip_v_t sip_init(input logic [WORD_W-1:0] k0,
                                      input logic [WORD_W-1:0] k1,
                                      input logic [WORD_W-1:0] m);
    sip_v_t v;
    v[0] = SIP_C0 ^ k0;
    v[1] = SIP_C1 ^ k1;
    v[2] = SIP_C2 ^ k0;
    v[3] = SIP_C3 ^ k1 ^ m;
    sip_init = v;
  endfunction

  function automatic sip_v_t sip_round(input sip_v_t vi);
    sip_v_t v;
    v = vi;
    v[0] = v[0] + v[1]; v[1] = rotl(v[1], 13); v[1] = v[1] ^ v[0]; v[0] = rotl(v[0], 32);
    v[2] = v[2] + v[3]; v[3] = rotl(v[3], 16); v[3] = v[3] ^ v[2];
    v[0] = v[0] + v[3]; v[3] = rotl(v[3], 21); v[3] = v[3] ^ v[0];
    v[2] = v[2] + v[1]; v[1] = rotl(v[1], 17); v[1] = v[1] ^ v[2]; v[2] = rotl(v[2], 32);
    sip_round = v;
  endfunction

  function automatic logic [WORD_W-1:0] bit_rev(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] r;
    for (int i = 0; i < WORD_W; i++) begin
      r[i] = x[WORD_W-1-i];
    end
    bit_rev = r;
  endfunction

endpackage

### sv/mhps_if.sv
// ----------------------------------------------------------------------------
// mhps_if
// Valid/ready channels of the pair-search engine: items in, results out,
// configuration writes.
// ----------------------------------------------------------------------------
interface mhps_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [mhps_pkg::IDX_W-1:0] index;

  modport source (output valid, output op, output index, input ready);
  modport sink   (input valid, input op, input index, output ready);
endinterface

interface mhps_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [mhps_pkg::WORD_W-1:0] solution;

  modport source (output valid, output found, output solution, input ready);
  modport sink   (input valid, input found, input solution, output ready);
endinterface

interface mhps_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mhps_pkg::CFG_IDX_W-1:0] index;
  logic [mhps_pkg::WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/memory_hard_pair_search_pow.sv
// ----------------------------------------------------------------------------
// memory_hard_pair_search_pow
// SipHash-2-4 pair-search proof-of-work engine with an on-chip slab.
// ----------------------------------------------------------------------------
// After reset the slab (2^SLAB_BITS entries) is swept to zero, one entry per
// cycle, and in_ch.ready stays low until the sweep ends; cfg writes are taken
// throughout. One SipHash round unit does all hashing at one round per cycle,
// and one item is in flight at a time. A fill word occupies the engine for its
// load, 8 rounds and slab write; a fill index at or above the slab size is
// dropped in the accept cycle. A search word runs two hashes back to back with
// a slab read in between; its result is offered in the same cycle that the
// input reopens for the next word, and both wait while an earlier result has
// not left the output register. A result waiting in the output register does
// not block the input; only a search that finishes while the register is
// still occupied stalls until it drains.
// ----------------------------------------------------------------------------
module memory_hard_pair_search_pow (
  input  logic       clk,
  input  logic       rst_n,
  mhps_in_if.sink    in_ch,
  mhps_out_if.source out_ch,
  mhps_cfg_if.sink   cfg_ch
);
  import mhps_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_FIN,
    ST_READ,
    ST_CHECK
  } state_t;

  state_t                 state_r, state_nxt;
  logic [ROUND_W-1:0]     rnd_r, rnd_nxt;
  logic                   second_r, second_nxt;   // running H0(l) of a search
  logic                   op_r, op_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [IDX_W-1:0]       msg_r, msg_nxt;
  logic [SLAB_BITS-1:0]   lhs_r, lhs_nxt;
  logic [WORD_W-1:0]      h_r, h_nxt;
  logic [WORD_W-1:0]      sum_r, sum_nxt;
  sip_v_t                 v_r, v_nxt;
  logic [SLAB_BITS-1:0]   clr_r, clr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   found_r, found_nxt;
  logic [WORD_W-1:0]      sol_r, sol_nxt;
  logic [WORD_W-1:0]      nonce_low_r, nonce_low_nxt;
  logic [WORD_W-1:0]      nonce_high_r, nonce_high_nxt;
  logic [WORD_W-1:0]      diff_r, diff_nxt;

  logic                   ram_we;
  logic [SLAB_BITS-1:0]   ram_waddr;
  logic [SLAB_BITS-1:0]   ram_wdata;
  logic [SLAB_BITS-1:0]   ram_raddr;
  logic [SLAB_BITS-1:0]   ram_rdata;

  sip_v_t                 v_in;
  logic [WORD_W-1:0]      hash_w;
  logic [WORD_W-1:0]      k0_left, k0_right;
  logic                   pass_w;
  logic                   in_range_w;

  mhps_ram #(
    .WIDTH (SLAB_BITS),
    .DEPTH (2 ** SLAB_BITS)
  ) u_slab (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign k0_left    = nonce_low_r | TOP_BIT;
  assign k0_right   = nonce_low_r & ~TOP_BIT;
  assign hash_w     = v_r[0] ^ v_r[1] ^ v_r[2] ^ v_r[3];
  assign pass_w     = ((sum_r & bit_rev(diff_r)) == '0) && (bit_rev(~sum_r) > diff_r);
  assign in_range_w = (in_ch.index >> SLAB_BITS) == '0;

  // message and finalization words folded in ahead of the shared round
  always_comb begin
    v_in = v_r;
    if (rnd_r == RND_MSG_FOLD) begin
      v_in[0] = v_r[0] ^ WORD_W'(msg_r);
      v_in[3] = v_r[3] ^ SIP_B;
    end else if (rnd_r == RND_FINAL) begin
      v_in[0] = v_r[0] ^ SIP_B;
      v_in[2] = v_r[2] ^ SIP_FF;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    rnd_nxt        = rnd_r;
    second_nxt     = second_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    msg_nxt        = msg_r;
    lhs_nxt        = lhs_r;
    h_nxt          = h_r;
    sum_nxt        = sum_r;
    v_nxt          = v_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = out_valid_r;
    found_nxt      = found_r;
    sol_nxt        = sol_r;
    nonce_low_nxt  = nonce_low_r;
    nonce_high_nxt = nonce_high_r;
    diff_nxt       = diff_r;
    ram_we         = 1'b0;
    ram_waddr      = clr_r;
    ram_wdata      = '0;
    ram_raddr      = SLAB_BITS'(WORD_W'(0) - hash_w);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_NONCE_LOW:  nonce_low_nxt  = cfg_ch.data;
        CFG_NONCE_HIGH: nonce_high_nxt = cfg_ch.data;
        CFG_DIFFICULTY: diff_nxt       = cfg_ch.data;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = in_ch.op;
          idx_nxt    = in_ch.index;
          msg_nxt    = in_ch.index;
          second_nxt = 1'b0;
          rnd_nxt    = '0;
          if (in_ch.op == OP_SEARCH) begin
            v_nxt     = sip_init(k0_right, nonce_high_r, WORD_W'(in_ch.index));
            state_nxt = ST_HASH;
          end else if (in_range_w) begin
            v_nxt     = sip_init(k0_left, nonce_high_r, WORD_W'(in_ch.index));
            state_nxt = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        v_nxt   = sip_round(v_in);
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (op_r == OP_FILL) begin
          ram_we    = 1'b1;
          ram_waddr = hash_w[SLAB_BITS-1:0];
          ram_wdata = idx_r[SLAB_BITS-1:0];
          state_nxt = ST_IDLE;
        end else if (!second_r) begin
          // slab read issued here with address -h
          h_nxt     = hash_w;
          state_nxt = ST_READ;
        end else begin
          sum_nxt   = hash_w + h_r;
          state_nxt = ST_CHECK;
        end
      end
      ST_READ: begin
        lhs_nxt    = ram_rdata;
        msg_nxt    = IDX_W'(ram_rdata);
        v_nxt      = sip_init(k0_left, nonce_high_r, WORD_W'(ram_rdata));
        second_nxt = 1'b1;
        rnd_nxt    = '0;
        state_nxt  = ST_HASH;
      end
      ST_CHECK: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          found_nxt     = pass_w;
          sol_nxt       = pass_w ? {IDX_W'(lhs_r), idx_r} : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      nonce_low_r  <= '0;
      nonce_high_r <= '0;
      diff_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
      nonce_low_r  <= nonce_low_nxt;
      nonce_high_r <= nonce_high_nxt;
      diff_r       <= diff_nxt;
    end
    rnd_r    <= rnd_nxt;
    second_r <= second_nxt;
    op_r     <= op_nxt;
    idx_r    <= idx_nxt;
    msg_r    <= msg_nxt;
    lhs_r    <= lhs_nxt;
    h_r      <= h_nxt;
    sum_r    <= sum_nxt;
    v_r      <= v_nxt;
    found_r  <= found_nxt;
    sol_r    <= sol_nxt;
  end

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = found_r;
  assign out_ch.solution = sol_r;

endmodule

### sv/mhps_ram.sv
// ----------------------------------------------------------------------------
// mhps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mhps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/mhps_checker.sv
// ----------------------------------------------------------------------------
// mhps_checker
// Port-level checks on the pair-search engine, bound to the top level.
// ----------------------------------------------------------------------------
module mhps_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_op,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_found,
  input logic [mhps_pkg::WORD_W-1:0] out_solution
);
  import mhps_pkg::*;

  // a result word stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // slab sweep keeps the input closed right after reset
  a_reset_closed: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during slab clear");

  // a search word occupies the engine
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_SEARCH) |=> !in_ready)
    else $error("input open while a search runs");

  // a failed search carries a zero solution
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_solution == '0)
    else $error("nonzero solution on a failed search");

endmodule

bind memory_hard_pair_search_pow mhps_checker u_mhps_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_op        (in_ch.op),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_found    (out_ch.found),
  .out_solution (out_ch.solution)
);
